// File: rtl/c8x_pkg.sv
// Shared types and constants for the CHIP-8 execute unit.
`timescale 1ns / 1ps
package c8x_pkg;

  localparam logic [1:0] FUNC_EXEC = 2'd0;
  localparam logic [1:0] FUNC_MEMWR = 2'd1;
  localparam logic [1:0] FUNC_ROWRD = 2'd2;

  localparam logic [15:0] PC_RESET = 16'd512;
  localparam logic [7:0] GLYPH_BYTES = 8'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] instruction;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [4:0]  row_select;
  } in_item_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic [15:0] index_value;
    logic [63:0] row_pixels;
    logic        display_dirty;
    logic        stack_fault;
    logic        waiting_for_key;
    logic        illegal_opcode;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
  } out_item_t;

  // Binary to decimal digits of an 8-bit value: hundreds, tens, ones.
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [7:0] h;
    logic [7:0] t;
    logic [7:0] r;
    begin
      h = (v >= 8'd200) ? 8'd2 : (v >= 8'd100) ? 8'd1 : 8'd0;
      r = v - h * 8'd100;
      t = 8'd0;
      for (int k = 1; k < 10; k++) begin
        if (r >= 8'(k * 10)) t = 8'(k);
      end
      r = r - t * 8'd10;
      to_bcd = {h[3:0], t[3:0], r[3:0]};
    end
  endfunction

endpackage

// File: rtl/c8x_mem.sv
// Byte-wide main memory, one port, registered read.
`timescale 1ns / 1ps
module c8x_mem #(
  parameter int MEM_BYTES = 4096,
  parameter int AW = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/c8x_disp.sv
// Display row memory, one port, registered read, with a row valid bit per row.
`timescale 1ns / 1ps
module c8x_disp #(
  parameter int DISPLAY_WIDTH = 64,
  parameter int DISPLAY_HEIGHT = 32,
  parameter int RW = $clog2(DISPLAY_HEIGHT)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear_all,
  input  logic                     we,
  input  logic [RW-1:0]            addr,
  input  logic [DISPLAY_WIDTH-1:0] wdata,
  output logic [DISPLAY_WIDTH-1:0] rdata
);
  logic [DISPLAY_WIDTH-1:0] rows [DISPLAY_HEIGHT];
  logic [DISPLAY_HEIGHT-1:0] vld;
  logic [DISPLAY_WIDTH-1:0] raw;
  logic                     rvld;

  always_ff @(posedge clk) begin
    if (we) begin
      rows[addr] <= wdata;
    end
    raw <= rows[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vld <= '0;
      rvld <= 1'b0;
    end else begin
      rvld <= vld[addr];
      if (we) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld ? raw : '0;
endmodule

// File: rtl/chip8_instruction_execute.sv
// CHIP-8 execute unit: sequencer, register file and the state memories.
// Steps: simple instructions, clear, host writes and unknown func pass S_EXEC, S_DONE;
// row reads add S_ROW_WT; draw repeats S_DRAW_RD/WT/WR per sprite row; FX55 stays in S_ST
// per register; FX65 repeats S_LD_RD/WT per register; FX33 writes three digits in S_BCD;
// a stalled result beat holds the unit in S_DONE. One item at a time; the next input beat
// is taken once the result is in the output register (it may wait there while work goes on).
// Reset (rst, synchronous): registers, timers, I and stack level clear, PC 512,
// display rows read as zero through per-row valid bits; main memory undefined.
`timescale 1ns / 1ps
module chip8_instruction_execute #(
  parameter int MEM_BYTES = 4096,
  parameter int DISPLAY_WIDTH = 64,
  parameter int DISPLAY_HEIGHT = 32,
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  c8x_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output c8x_pkg::out_item_t  out_data
);
  import c8x_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(DISPLAY_HEIGHT);
  localparam int SW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DRAW_RD, S_DRAW_WT, S_DRAW_WR, S_CLR,
    S_ST, S_LD_RD, S_LD_WT, S_BCD, S_ROW_WT, S_DONE
  } state_t;

  state_t state;
  in_item_t cur;

  // architectural registers
  logic [7:0]  v [16];
  logic [15:0] idx, pc;
  logic [15:0] stk [STACK_DEPTH];
  logic [4:0]  sp;
  logic [7:0]  dly, snd;
  logic        dirty, fault, waitk, illeg;

  // sequencing
  logic [4:0]  step;
  logic [7:0]  sprite;
  logic [7:0]  px, py;
  logic [11:0] bcd;

  // memory ports
  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wd, m_rd;
  logic          d_we, d_clr;
  logic [RW-1:0] d_addr;
  logic [DISPLAY_WIDTH-1:0] d_wd, d_rd;

  c8x_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  c8x_disp #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_disp (
    .clk(clk), .rst(rst), .clear_all(d_clr), .we(d_we), .addr(d_addr),
    .wdata(d_wd), .rdata(d_rd)
  );

  // decoded fields
  logic [3:0]  fx, fy, fn;
  logic [7:0]  kk, vx, vy;
  logic [15:0] w;
  assign w  = cur.instruction;
  assign fx = w[11:8];
  assign fy = w[7:4];
  assign fn = w[3:0];
  assign kk = w[7:0];
  assign vx = v[fx];
  assign vy = v[fy];

  // sprite row placement: XOR mask of 8 bits at column px, wrapping
  logic [DISPLAY_WIDTH-1:0] smask;
  always_comb begin
    smask = '0;
    for (int b = 0; b < 8; b++) begin
      if (sprite[7-b]) begin
        smask[DISPLAY_WIDTH-1-((int'(px) + b) % DISPLAY_WIDTH)] = 1'b1;
      end
    end
  end

  logic [RW-1:0] drow;
  assign drow = RW'((int'(py) + int'(step)) % DISPLAY_HEIGHT);

  // memory address: I + step, or host address
  always_comb begin
    m_we = 1'b0;
    m_wd = v[step[3:0]];
    m_addr = AW'(idx + 16'(step));
    d_we = 1'b0;
    d_clr = 1'b0;
    d_addr = drow;
    d_wd = d_rd ^ smask;
    case (state)
      S_EXEC: begin
        if (cur.func == FUNC_MEMWR) begin
          m_we = 1'b1;
          m_addr = AW'(cur.mem_address);
          m_wd = cur.mem_data;
        end else if (cur.func == FUNC_ROWRD) begin
          d_addr = RW'(cur.row_select);
        end else if (cur.func == FUNC_EXEC && w == 16'h00E0) begin
          d_clr = 1'b1;
        end
      end
      // hold the row address so the registered read stays on the selected row
      S_ROW_WT, S_DONE: begin
        if (cur.func == FUNC_ROWRD) d_addr = RW'(cur.row_select);
      end
      S_ST: m_we = 1'b1;
      S_BCD: begin
        m_we = 1'b1;
        m_wd = (step == 5'd0) ? {4'd0, bcd[11:8]} :
               (step == 5'd1) ? {4'd0, bcd[7:4]} : {4'd0, bcd[3:0]};
      end
      S_DRAW_WR: d_we = 1'b1;
      default: ;
    endcase
  end

  // first set key
  logic [3:0] firstkey;
  always_comb begin
    firstkey = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (cur.keys[k]) firstkey = 4'(k);
    end
  end

  logic [15:0] pc2;
  logic [8:0]  sum9;
  logic [16:0] isum;
  assign pc2  = pc + 16'd2;
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign isum = {1'b0, idx} + {9'd0, vx};

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < 16; i++) v[i] <= 8'd0;
      idx <= '0;
      pc <= PC_RESET;
      sp <= '0;
      dly <= '0;
      snd <= '0;
      dirty <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            step <= '0;
            fault <= 1'b0;
            waitk <= 1'b0;
            illeg <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          if (cur.func == FUNC_ROWRD) begin
            state <= S_ROW_WT;
          end else if (cur.func == FUNC_EXEC) begin
            pc <= pc2;
            case (w[15:12])
              4'h0: begin
                if (w == 16'h00E0) dirty <= 1'b1;
                else if (w == 16'h00EE) begin
                  if (sp == 5'd0 || 32'(sp) > STACK_DEPTH) fault <= 1'b1;
                  else begin
                    sp <= sp - 5'd1;
                    pc <= stk[SW'(sp - 5'd1)];
                  end
                end else illeg <= 1'b1;
              end
              4'h1: pc <= {4'd0, w[11:0]};
              4'h2: begin
                if (32'(sp) >= STACK_DEPTH) fault <= 1'b1;
                else begin
                  stk[SW'(sp)] <= pc2;
                  sp <= sp + 5'd1;
                  pc <= {4'd0, w[11:0]};
                end
              end
              4'h3: if (vx == kk) pc <= pc + 16'd4;
              4'h4: if (vx != kk) pc <= pc + 16'd4;
              4'h5: begin
                if (fn != 4'd0) illeg <= 1'b1;
                else if (vx == vy) pc <= pc + 16'd4;
              end
              4'h6: v[fx] <= kk;
              4'h7: v[fx] <= vx + kk;
              4'h8: begin
                // flag goes first, result overwrites when x is F
                case (fn)
                  4'h0: v[fx] <= vy;
                  4'h1: v[fx] <= vx | vy;
                  4'h2: v[fx] <= vx & vy;
                  4'h3: v[fx] <= vx ^ vy;
                  4'h4: begin
                    v[15] <= {7'd0, sum9[8]};
                    v[fx] <= (fx == 4'hF) ? ({7'd0, sum9[8]} + vy) : sum9[7:0];
                  end
                  4'h5: begin
                    v[15] <= {7'd0, vx > vy};
                    v[fx] <= (fx == 4'hF) ? ({7'd0, vx > vy} - vy) : vx - vy;
                  end
                  4'h6: begin
                    v[15] <= {7'd0, vx[0]};
                    v[fx] <= (fx == 4'hF) ? 8'd0 : {1'b0, vx[7:1]};
                  end
                  4'h7: begin
                    v[15] <= {7'd0, vy > vx};
                    v[fx] <= (fx == 4'hF) ? (vy - {7'd0, vy > vx}) : vy - vx;
                  end
                  4'hE: begin
                    v[15] <= {7'd0, vx[7]};
                    v[fx] <= (fx == 4'hF) ? {6'd0, vx[7], 1'b0} : {vx[6:0], 1'b0};
                  end
                  default: illeg <= 1'b1;
                endcase
              end
              4'h9: begin
                if (fn != 4'd0) illeg <= 1'b1;
                else if (vx != vy) pc <= pc + 16'd4;
              end
              4'hA: idx <= {4'd0, w[11:0]};
              4'hB: pc <= {4'd0, w[11:0]} + {8'd0, v[0]};
              4'hC: v[fx] <= cur.random_byte & kk;
              4'hD: begin
                px <= vx;
                py <= vy;
                v[15] <= 8'd0;
                dirty <= 1'b1;
                if (fn != 4'd0) state <= S_DRAW_RD;
              end
              4'hE: begin
                if (kk == 8'h9E) begin
                  if (vx < 8'd16 && cur.keys[vx[3:0]]) pc <= pc + 16'd4;
                end else if (kk == 8'hA1) begin
                  if (!(vx < 8'd16 && cur.keys[vx[3:0]])) pc <= pc + 16'd4;
                end else illeg <= 1'b1;
              end
              default: begin
                case (kk)
                  8'h07: v[fx] <= dly;
                  8'h0A: begin
                    if (cur.keys != 16'd0) v[fx] <= {4'd0, firstkey};
                    else begin
                      pc <= pc;
                      waitk <= 1'b1;
                    end
                  end
                  8'h15: dly <= vx;
                  8'h18: snd <= vx;
                  8'h1E: begin
                    v[15] <= {7'd0, isum > 17'd255};
                    idx <= isum[15:0];
                  end
                  8'h29: idx <= {8'd0, vx} * {8'd0, GLYPH_BYTES};
                  8'h33: begin
                    bcd <= to_bcd(vx);
                    state <= S_BCD;
                  end
                  8'h55: state <= S_ST;
                  8'h65: state <= S_LD_RD;
                  default: illeg <= 1'b1;
                endcase
              end
            endcase
          end
        end
        S_ROW_WT: state <= S_DONE;
        // draw: read sprite byte, read row, write row
        S_DRAW_RD: state <= S_DRAW_WT;
        S_DRAW_WT: begin
          sprite <= m_rd;
          state <= S_DRAW_WR;
        end
        S_DRAW_WR: begin
          if ((d_rd & smask) != '0) v[15] <= 8'd1;
          step <= step + 5'd1;
          state <= (step[3:0] == fn - 4'd1) ? S_DONE : S_DRAW_RD;
        end
        S_ST: begin
          step <= step + 5'd1;
          if (step[3:0] == fx) state <= S_DONE;
        end
        S_LD_RD: state <= S_LD_WT;
        S_LD_WT: begin
          v[step[3:0]] <= m_rd;
          step <= step + 5'd1;
          state <= (step[3:0] == fx) ? S_DONE : S_LD_RD;
        end
        S_BCD: begin
          step <= step + 5'd1;
          if (step == 5'd2) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register: loaded as the beat is issued
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.program_counter <= pc;
      out_data.index_value <= idx;
      out_data.row_pixels <= (cur.func == FUNC_ROWRD &&
          32'(cur.row_select) < DISPLAY_HEIGHT) ? 64'(d_rd) << (64 - DISPLAY_WIDTH) : 64'd0;
      out_data.display_dirty <= dirty;
      out_data.stack_fault <= fault;
      out_data.waiting_for_key <= waitk;
      out_data.illegal_opcode <= illeg;
      out_data.delay_value <= dly;
      out_data.sound_value <= snd;
    end
  end
endmodule

// File: rtl/c8x_check.sv
// Port-level checker for the execute unit, bound to the top level.
`timescale 1ns / 1ps
module c8x_check (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input c8x_pkg::out_item_t out_data
);
  import c8x_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while busy");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_data.stack_fault, out_data.waiting_for_key,
                              out_data.illegal_opcode}) <= 1)
    else $error("more than one status flag");

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat right after reset");
endmodule

bind chip8_instruction_execute c8x_check u_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: bench/chip8_instruction_execute_test.sv
// Testbench for the CHIP-8 execute unit: random and directed beats checked against a predictor.
`timescale 1ns / 1ps

// Holds the machine state mirror and the queue of expected result beats.
class chip8_scoreboard;
  logic [7:0]  vreg [16];
  logic [15:0] idx;
  logic [15:0] pc;
  logic [15:0] rstack [16];
  int          sp;
  logic [7:0]  mem [4096];
  bit          written [4096];
  logic [63:0] rows [32];
  logic [7:0]  dly;
  logic [7:0]  snd;
  logic        dirty;
  c8x_pkg::out_item_t pending_results[$];
  int          errors;

  function new();
    for (int k = 0; k < 16; k++) vreg[k] = 8'd0;
    for (int k = 0; k < 16; k++) rstack[k] = 16'd0;
    for (int k = 0; k < 4096; k++) mem[k] = 8'd0;
    for (int k = 0; k < 4096; k++) written[k] = 1'b0;
    for (int k = 0; k < 32; k++) rows[k] = 64'd0;
    idx = 16'd0;
    pc = c8x_pkg::PC_RESET;
    sp = 0;
    dly = 8'd0;
    snd = 8'd0;
    dirty = 1'b0;
    errors = 0;
  endfunction

  function logic [11:0] maddr(int off);
    return 12'((int'(idx) + off) % 4096);
  endfunction

  // Predict the result of one accepted input beat.
  function void note_input(c8x_pkg::in_item_t b);
    c8x_pkg::out_item_t r;
    logic [15:0] w;
    logic [3:0] x, y, n;
    logic [7:0] kk, vx, vy, bits;
    logic [11:0] nnn;
    logic [8:0] sum;
    int ky, row, col;
    r = '0;
    w = b.instruction;
    if (b.func == c8x_pkg::FUNC_MEMWR) begin
      mem[b.mem_address] = b.mem_data;
      written[b.mem_address] = 1'b1;
    end else if (b.func == c8x_pkg::FUNC_ROWRD) begin
      r.row_pixels = rows[b.row_select];
    end else if (b.func == c8x_pkg::FUNC_EXEC) begin
      x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0]; nnn = w[11:0];
      pc = pc + 16'd2;
      vx = vreg[x]; vy = vreg[y];
      case (w[15:12])
        4'h0: begin
          if (w == 16'h00E0) begin
            for (int k = 0; k < 32; k++) rows[k] = 64'd0;
            dirty = 1'b1;
          end else if (w == 16'h00EE) begin
            if (sp == 0) r.stack_fault = 1'b1;
            else begin sp--; pc = rstack[sp]; end
          end else r.illegal_opcode = 1'b1;
        end
        4'h1: pc = {4'h0, nnn};
        4'h2: begin
          if (sp >= 16) r.stack_fault = 1'b1;
          else begin rstack[sp] = pc; sp++; pc = {4'h0, nnn}; end
        end
        4'h3: if (vx == kk) pc = pc + 16'd2;
        4'h4: if (vx != kk) pc = pc + 16'd2;
        4'h5: begin
          if (n != 4'h0) r.illegal_opcode = 1'b1;
          else if (vx == vy) pc = pc + 16'd2;
        end
        4'h6: vreg[x] = kk;
        4'h7: vreg[x] = vx + kk;
        4'h8: begin
          case (n)
            4'h0: vreg[x] = vy;
            4'h1: vreg[x] = vx | vy;
            4'h2: vreg[x] = vx & vy;
            4'h3: vreg[x] = vx ^ vy;
            4'h4: begin
              sum = {1'b0, vx} + {1'b0, vy};
              vreg[15] = {7'd0, sum[8]};
              vreg[x] = vreg[x] + vy;
            end
            4'h5: begin
              vreg[15] = {7'd0, vx > vy};
              vreg[x] = vreg[x] - vy;
            end
            4'h6: begin
              vreg[15] = {7'd0, vx[0]};
              vreg[x] = vreg[x] >> 1;
            end
            4'h7: begin
              vreg[15] = {7'd0, vy > vx};
              vreg[x] = vy - vreg[x];
            end
            4'hE: begin
              vreg[15] = {7'd0, vx[7]};
              vreg[x] = vreg[x] << 1;
            end
            default: r.illegal_opcode = 1'b1;
          endcase
        end
        4'h9: begin
          if (n != 4'h0) r.illegal_opcode = 1'b1;
          else if (vx != vy) pc = pc + 16'd2;
        end
        4'hA: idx = {4'h0, nnn};
        4'hB: pc = {4'h0, nnn} + {8'h0, vreg[0]};
        4'hC: vreg[x] = b.random_byte & kk;
        4'hD: begin
          vreg[15] = 8'd0;
          for (int i = 0; i < int'(n); i++) begin
            bits = mem[maddr(i)];
            row = (int'(vy) + i) % 32;
            for (int j = 0; j < 8; j++) begin
              if (bits[7 - j]) begin
                col = (int'(vx) + j) % 64;
                if (rows[row][63 - col]) vreg[15] = 8'd1;
                rows[row][63 - col] = ~rows[row][63 - col];
              end
            end
          end
          dirty = 1'b1;
        end
        4'hE: begin
          if (kk == 8'h9E) begin
            if (vx < 16 && b.keys[vx[3:0]]) pc = pc + 16'd2;
          end else if (kk == 8'hA1) begin
            if (!(vx < 16 && b.keys[vx[3:0]])) pc = pc + 16'd2;
          end else r.illegal_opcode = 1'b1;
        end
        default: begin
          case (kk)
            8'h07: vreg[x] = dly;
            8'h0A: begin
              ky = -1;
              for (int i = 15; i >= 0; i--) if (b.keys[i]) ky = i;
              if (ky >= 0) vreg[x] = 8'(ky);
              else begin pc = pc - 16'd2; r.waiting_for_key = 1'b1; end
            end
            8'h15: dly = vx;
            8'h18: snd = vx;
            8'h1E: begin
              vreg[15] = {7'd0, (int'(vx) + int'(idx)) > 255};
              idx = idx + {8'h0, vx};
            end
            8'h29: idx = 16'(int'(c8x_pkg::GLYPH_BYTES) * int'(vx));
            8'h33: begin
              mem[maddr(0)] = vx / 100;
              mem[maddr(1)] = (vx / 10) % 10;
              mem[maddr(2)] = vx % 10;
              for (int i = 0; i < 3; i++) written[maddr(i)] = 1'b1;
            end
            8'h55: begin
              for (int i = 0; i <= int'(x); i++) begin
                mem[maddr(i)] = vreg[i];
                written[maddr(i)] = 1'b1;
              end
            end
            8'h65: for (int i = 0; i <= int'(x); i++) vreg[i] = mem[maddr(i)];
            default: r.illegal_opcode = 1'b1;
          endcase
        end
      endcase
    end
    r.program_counter = pc;
    r.index_value = idx;
    r.display_dirty = dirty;
    r.delay_value = dly;
    r.sound_value = snd;
    pending_results.push_back(r);
  endfunction

  function void report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endfunction

  function void check_result(c8x_pkg::out_item_t got);
    c8x_pkg::out_item_t e;
    if (pending_results.size() == 0) begin
      report("unexpected result beat", 64'(got.program_counter), 64'd0);
      return;
    end
    e = pending_results.pop_front();
    if (got.program_counter !== e.program_counter)
      report("program_counter", got.program_counter, e.program_counter);
    if (got.index_value !== e.index_value)
      report("index_value", got.index_value, e.index_value);
    if (got.row_pixels !== e.row_pixels) report("row_pixels", got.row_pixels, e.row_pixels);
    if (got.display_dirty !== e.display_dirty)
      report("display_dirty", got.display_dirty, e.display_dirty);
    if (got.stack_fault !== e.stack_fault) report("stack_fault", got.stack_fault, e.stack_fault);
    if (got.waiting_for_key !== e.waiting_for_key)
      report("waiting_for_key", got.waiting_for_key, e.waiting_for_key);
    if (got.illegal_opcode !== e.illegal_opcode)
      report("illegal_opcode", got.illegal_opcode, e.illegal_opcode);
    if (got.delay_value !== e.delay_value) report("delay_value", got.delay_value, e.delay_value);
    if (got.sound_value !== e.sound_value) report("sound_value", got.sound_value, e.sound_value);
  endfunction
endclass

module chip8_instruction_execute_test;
  import c8x_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  chip8_scoreboard sb;
  bit sent_all;
  int idle_cycles;
  int stall_left;

  chip8_instruction_execute dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, and stretches of none.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Valid stays up after an accepted beat only until the next call, in the same step.
  task automatic send_beat(input in_item_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
  endtask

  function automatic in_item_t rand_beat();
    in_item_t b;
    b.func = 2'($urandom_range(0, 3));
    b.instruction = 16'($urandom);
    b.keys = 16'($urandom);
    b.random_byte = 8'($urandom);
    b.mem_address = 12'($urandom);
    b.mem_data = 8'($urandom);
    b.row_select = 5'($urandom);
    return b;
  endfunction

  task automatic host_write(input logic [11:0] a, input logic [7:0] d);
    in_item_t b;
    b = rand_beat();
    b.func = FUNC_MEMWR;
    b.mem_address = a;
    b.mem_data = d;
    send_beat(b);
  endtask

  // Host-writes each byte that the instruction is about to read and that was never written.
  task automatic cover_reads(input logic [15:0] w);
    int cnt;
    logic [11:0] a;
    cnt = 0;
    if (w[15:12] == 4'hD) cnt = int'(w[3:0]);
    else if (w[15:12] == 4'hF && w[7:0] == 8'h65) cnt = int'(w[11:8]) + 1;
    for (int i = 0; i < cnt; i++) begin
      a = sb.maddr(i);
      if (!sb.written[a]) host_write(a, 8'($urandom));
    end
  endtask

  task automatic exec(input logic [15:0] w, input logic [15:0] keys);
    in_item_t b;
    b = rand_beat();
    b.func = FUNC_EXEC;
    b.instruction = w;
    b.keys = keys;
    cover_reads(w);
    send_beat(b);
  endtask

  task automatic row_read(input logic [4:0] r);
    in_item_t b;
    b = rand_beat();
    b.func = FUNC_ROWRD;
    b.row_select = r;
    send_beat(b);
  endtask

  // Instruction word biased toward legal opcodes with random operands.
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    logic [7:0] fx [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    logic [3:0] alu [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
    w = 16'($urandom);
    if ($urandom_range(0, 9) == 0) return w;
    case (w[15:12])
      4'h0: w = $urandom_range(0, 1) ? 16'h00E0 : 16'h00EE;
      4'h5, 4'h9: w[3:0] = 4'h0;
      4'h8: w[3:0] = alu[$urandom_range(0, 8)];
      4'hD: w[3:0] = 4'($urandom_range(0, 6));
      4'hE: w[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
      4'hF: w[7:0] = fx[$urandom_range(0, 8)];
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    in_item_t b;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sent_all = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: row reads of an empty display and an unknown func.
    row_read(5'd0);
    row_read(5'd31);
    b = rand_beat();
    b.func = 2'd3;
    send_beat(b);
    exec(16'h00EE, 16'h0000);          // return on empty stack
    exec(16'h60FF, 16'h0000);
    exec(16'h6101, 16'h0000);
    exec(16'h8014, 16'h0000);          // add with carry
    exec(16'h8015, 16'h0000);          // subtract, flag only if strictly greater
    exec(16'h6F80, 16'h0000);
    exec(16'h8FFE, 16'h0000);          // flag register as destination
    exec(16'hAFFF, 16'h0000);
    exec(16'hF01E, 16'h0000);          // index add overflow
    exec(16'h6011, 16'h0000);
    exec(16'hE09E, 16'hFFFF);          // key number above 15
    exec(16'hF00A, 16'h0000);          // wait for key, none pressed
    exec(16'hF30A, 16'h8000);
    exec(16'h6AFF, 16'h0000);
    exec(16'hDAA5, 16'h0000);          // draw wrapping off both edges
    row_read(5'd31);
    exec(16'hF033, 16'h0000);
    exec(16'hFF55, 16'h0000);
    exec(16'hFF65, 16'h0000);
    exec(16'h5121, 16'h0000);          // illegal
    exec(16'hF0FF, 16'h0000);          // illegal
    for (int k = 0; k < 17; k++) exec(16'h2FFE, 16'h0000); // overflow the stack
    exec(16'h00E0, 16'h0000);

    for (int k = 0; k < 1400; k++) begin
      b = rand_beat();
      if (b.func == FUNC_EXEC || $urandom_range(0, 3) != 0) begin
        b.func = ($urandom_range(0, 9) < 8) ? FUNC_EXEC : b.func;
        b.instruction = rand_instr();
        if ($urandom_range(0, 3) == 0) b.keys = 16'h0000;
      end
      if (b.func == FUNC_EXEC) cover_reads(b.instruction);
      send_beat(b);
    end
    in_valid <= 1'b0;
    sent_all = 1'b1;
  end

  // Receiver: random stalls, now and then a long one; accepted beats go to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        stall_left = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (sent_all && sb.pending_results.size() == 0) begin
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end
endmodule
